// File: hw/rtl/atba_pkg.sv
// ----------------------------------------------------------------------------
// atba_pkg
// shared types, constants and arithmetic helpers for the affine bbox block
// ----------------------------------------------------------------------------
`default_nettype none

package atba_pkg;

    localparam int FRAC_BITS    = 16;
    localparam int CORDIC_STEPS = 20;
    localparam int ANG_FRAC     = 30;
    localparam int DATA_W       = 32;
    localparam int PROD_W       = 2 * DATA_W;
    localparam int ACC_W        = PROD_W + 2;
    localparam int CNT_W        = $clog2(CORDIC_STEPS);
    localparam int CRD_W        = DATA_W + 2;
    localparam int ANG_W        = DATA_W + 3;

    // number of conditional subtracts of 360 << k that cover a 32-bit angle
    localparam int RED_STEPS = (FRAC_BITS < 23) ? (23 - FRAC_BITS) : 1;
    localparam int RED_KMAX  = RED_STEPS - 1;

    localparam logic signed [PROD_W-1:0] FULL_TURN = 64'sd360 <<< FRAC_BITS;
    localparam logic signed [ANG_W-1:0]  FULL_A    = ANG_W'(64'sd360 <<< FRAC_BITS);
    localparam logic signed [ANG_W-1:0]  HALF_A    = ANG_W'(64'sd180 <<< FRAC_BITS);
    localparam logic signed [ANG_W-1:0]  QUART_A   = ANG_W'(64'sd90 <<< FRAC_BITS);

    localparam logic signed [DATA_W-1:0] INV_GAIN   = 32'sd652032874;
    localparam logic signed [DATA_W-1:0] DEG_TO_RAD =
        DATA_W'(((64'd314159 << 30) + 64'd9000000) / 64'd18000000);
    localparam logic signed [DATA_W-1:0] ONE_FX = DATA_W'(64'sd1 <<< FRAC_BITS);

    typedef enum logic [1:0] {
        OP_SCALE = 2'd0,
        OP_TRANS = 2'd1,
        OP_ROT   = 2'd2,
        OP_PLACE = 2'd3
    } op_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCALE,
        ST_TRANS,
        ST_RED,
        ST_FOLD,
        ST_ZMUL,
        ST_ZRND,
        ST_CORD,
        ST_ROT,
        ST_PCHK,
        ST_PLACE,
        ST_DONE
    } state_t;

    typedef struct packed {
        state_t           phase;
        logic [CNT_W-1:0] step;
        logic [1:0]       idx;
        logic             load;
        logic             out_load;
    } cmd_t;

    typedef struct packed {
        logic box_en;
        logic out_busy;
    } status_t;

    function automatic logic signed [DATA_W-1:0] atan_q30(input logic [4:0] i);
        logic signed [DATA_W-1:0] r;
        case (i)
            5'd0:  r = 32'sd843314857;
            5'd1:  r = 32'sd497837829;
            5'd2:  r = 32'sd263043837;
            5'd3:  r = 32'sd133525159;
            5'd4:  r = 32'sd67021687;
            5'd5:  r = 32'sd33543516;
            5'd6:  r = 32'sd16775851;
            5'd7:  r = 32'sd8388437;
            5'd8:  r = 32'sd4194283;
            5'd9:  r = 32'sd2097149;
            5'd10: r = 32'sd1048576;
            5'd11: r = 32'sd524288;
            5'd12: r = 32'sd262144;
            5'd13: r = 32'sd131072;
            5'd14: r = 32'sd65536;
            5'd15: r = 32'sd32768;
            5'd16: r = 32'sd16384;
            5'd17: r = 32'sd8192;
            5'd18: r = 32'sd4096;
            5'd19: r = 32'sd2048;
            5'd20: r = 32'sd1024;
            5'd21: r = 32'sd512;
            5'd22: r = 32'sd256;
            5'd23: r = 32'sd128;
            5'd24: r = 32'sd64;
            5'd25: r = 32'sd32;
            5'd26: r = 32'sd16;
            5'd27: r = 32'sd8;
            5'd28: r = 32'sd4;
            5'd29: r = 32'sd2;
            default: r = '0;
        endcase
        return r;
    endfunction

    // add half an lsb and floor
    function automatic logic signed [ACC_W-1:0] rnd_shift(
        input logic signed [ACC_W-1:0] v, input int s);
        logic signed [ACC_W-1:0] h;
        h = '0;
        h[s-1] = 1'b1;
        return (v + h) >>> s;
    endfunction

    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] hi;
        logic signed [ACC_W-1:0] lo;
        hi = {{(ACC_W-DATA_W+1){1'b0}}, {(DATA_W-1){1'b1}}};
        lo = {{(ACC_W-DATA_W+1){1'b1}}, {(DATA_W-1){1'b0}}};
        if (v > hi) return hi[DATA_W-1:0];
        if (v < lo) return lo[DATA_W-1:0];
        return v[DATA_W-1:0];
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/affine_transform_bbox_accumulator.sv
// ----------------------------------------------------------------------------
// affine_transform_bbox_accumulator
// 2d affine matrix composition with running bounding box union, q16.16
// ----------------------------------------------------------------------------
//
//  channel   dir  handshake           payload
//  s_        in   s_tvalid/s_tready   s_tdata values and box, s_tuser op, box flag
//  m_        out  m_tvalid/m_tready   m_tdata matrix and union, m_tuser union valid
//  cfg_      in   cfg_wr_en           cfg_wr_data eps mode
//
//  one word in, one word out; scale, rotate and place share the 32x32
//  multiplier, and rotate also runs RED_STEPS angle reduction steps
//  and CORDIC_STEPS (20) cordic iterations through the cordic unit
//  a word is taken only while the sequencer is idle; the finished word waits
//  in the output register, and the next word is taken while it waits
//  synchronous active-low reset restores the identity matrix and empty union
//
`default_nettype none

module affine_transform_bbox_accumulator (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          cfg_wr_en,
    input  wire logic          cfg_wr_data,   // eps_mode
    input  wire logic          s_tvalid,
    output logic               s_tready,
    // value_x, value_y, angle_degrees, box_low_x, box_low_y, box_high_x, box_high_y
    input  wire logic [223:0]  s_tdata,
    // operation, box_present
    input  wire logic [2:0]    s_tuser,
    output logic               m_tvalid,
    input  wire logic          m_tready,
    // mat_a .. mat_f, union_min_x, union_min_y, union_max_x, union_max_y
    output logic [319:0]       m_tdata,
    // union_valid
    output logic               m_tuser
);
    import atba_pkg::*;

    cmd_t    cmd;
    status_t status;
    logic    in_ready;

    // sequencer
    atba_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_op    (op_t'(s_tuser[1:0])),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    // matrix, union and arithmetic
    atba_datapath u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_user     (s_tuser),
        .in_data     (s_tdata),
        .cmd         (cmd),
        .status      (status),
        .out_ready   (m_tready),
        .out_valid   (m_tvalid),
        .out_data    (m_tdata),
        .out_user    (m_tuser)
    );

    assign s_tready = in_ready;

endmodule

`default_nettype wire

// File: hw/rtl/atba_ctrl.sv
// ----------------------------------------------------------------------------
// atba_ctrl
// operation sequencer: steps the datapath through each operation
// ----------------------------------------------------------------------------
`default_nettype none

module atba_ctrl (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             in_valid,
    input  atba_pkg::op_t         in_op,
    output logic                  in_ready,
    input  atba_pkg::status_t     status,
    output atba_pkg::cmd_t        cmd
);
    import atba_pkg::*;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [1:0]       idx_reg, idx_next;
    logic             load, out_load;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            idx_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            idx_reg   <= idx_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg + 1'b1;
        idx_next   = idx_reg;
        load       = 1'b0;
        out_load   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                cnt_next = '0;
                idx_next = '0;
                if (in_valid) begin
                    load = 1'b1;
                    unique case (in_op)
                        OP_SCALE: state_next = ST_SCALE;
                        OP_TRANS: state_next = ST_TRANS;
                        OP_ROT:   state_next = ST_RED;
                        OP_PLACE: state_next = ST_PCHK;
                        default:  state_next = ST_IDLE;
                    endcase
                end
            end
            ST_SCALE: begin
                if (cnt_reg == CNT_W'(6)) state_next = ST_DONE;
            end
            ST_TRANS: state_next = ST_DONE;
            ST_RED: begin
                if (cnt_reg == CNT_W'(RED_KMAX)) state_next = ST_FOLD;
            end
            ST_FOLD: state_next = ST_ZMUL;
            ST_ZMUL: state_next = ST_ZRND;
            ST_ZRND: begin
                state_next = ST_CORD;
                cnt_next   = '0;
            end
            ST_CORD: begin
                if (cnt_reg == CNT_W'(CORDIC_STEPS - 1)) begin
                    state_next = ST_ROT;
                    cnt_next   = '0;
                    idx_next   = '0;
                end
            end
            ST_ROT: begin
                if (cnt_reg == CNT_W'(5)) begin
                    cnt_next = '0;
                    idx_next = idx_reg + 1'b1;
                    if (idx_reg == 2'd2) state_next = ST_DONE;
                end
            end
            ST_PCHK: begin
                cnt_next   = '0;
                state_next = status.box_en ? ST_PLACE : ST_DONE;
            end
            ST_PLACE: begin
                if (cnt_reg == CNT_W'(5)) begin
                    cnt_next = '0;
                    idx_next = idx_reg + 1'b1;
                    if (idx_reg == 2'd3) state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!status.out_busy) begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    assign in_ready     = (state_reg == ST_IDLE);
    assign cmd.phase    = state_reg;
    assign cmd.step     = cnt_reg;
    assign cmd.idx      = idx_reg;
    assign cmd.load     = load;
    assign cmd.out_load = out_load;

endmodule

`default_nettype wire

// File: hw/rtl/atba_datapath.sv
// ----------------------------------------------------------------------------
// atba_datapath
// matrix, union box, shared multiplier, angle reduction and cordic
// ----------------------------------------------------------------------------
`default_nettype none

module atba_datapath (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            cfg_wr_en,
    input  wire logic            cfg_wr_data,
    input  wire logic [2:0]      in_user,
    input  wire logic [223:0]    in_data,
    input  atba_pkg::cmd_t       cmd,
    output atba_pkg::status_t    status,
    input  wire logic            out_ready,
    output logic                 out_valid,
    output logic [319:0]         out_data,
    output logic                 out_user
);
    import atba_pkg::*;

    logic                     eps_reg;
    op_t                      op_reg;
    logic                     bp_reg;
    logic signed [DATA_W-1:0] vx_reg, vy_reg, lx_reg, ly_reg, hx_reg, hy_reg;
    logic signed [DATA_W-1:0] t_reg [6];
    logic signed [DATA_W-1:0] ub_reg [4];
    logic                     ud_reg;
    logic [DATA_W:0]          mag_reg;
    logic                     neg_reg, fneg_reg;
    logic signed [DATA_W-1:0] r_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  acc0_reg, acc1_reg;
    logic signed [CRD_W-1:0]  x_reg, y_reg, z_reg;
    logic [319:0]             out_data_reg;
    logic                     out_user_reg, out_valid_reg;

    logic signed [DATA_W-1:0] ma, mb, p_op, q_op, bx, by, cos_v, sin_v, ang_in, sat_x, sat_y;
    logic signed [CRD_W-1:0]  cx, sy;
    logic signed [ACC_W-1:0]  pe, pr;
    logic [2:0]               ie, io, sidx, widx;
    logic signed [PROD_W-1:0] sub_v;
    logic signed [ANG_W-1:0]  rr0, rr1, rr2, rr3;
    logic                     fneg;
    logic signed [CRD_W-1:0]  dx, dy;
    logic signed [DATA_W-1:0] at;

    assign ie   = {cmd.idx, 1'b0};
    assign io   = {cmd.idx, 1'b1};
    assign sidx = cmd.step[2:0];
    assign widx = sidx - 3'd1;
    assign p_op = t_reg[ie];
    assign q_op = t_reg[io];
    assign bx   = cmd.idx[1] ? hx_reg : lx_reg;
    assign by   = (cmd.idx[1] ^ cmd.idx[0]) ? hy_reg : ly_reg;
    assign cx   = fneg_reg ? -x_reg : x_reg;
    assign sy   = fneg_reg ? -y_reg : y_reg;
    assign cos_v = cx[DATA_W-1:0];
    assign sin_v = sy[DATA_W-1:0];
    assign pe   = ACC_W'(prod_reg);
    assign pr   = rnd_shift(pe, FRAC_BITS);
    assign sat_x = sat32(acc0_reg);
    assign sat_y = sat32(acc1_reg);
    assign ang_in = in_data[95:64];

    always_comb begin
        ma = '0;
        mb = '0;
        case (cmd.phase)
            ST_SCALE: begin
                ma = (sidx < 3'd6) ? t_reg[sidx] : '0;
                mb = cmd.step[0] ? vy_reg : vx_reg;
            end
            ST_ZMUL: begin
                ma = r_reg;
                mb = DEG_TO_RAD;
            end
            ST_ROT: begin
                case (cmd.step[1:0])
                    2'd0:    begin ma = p_op; mb = cos_v; end
                    2'd1:    begin ma = q_op; mb = sin_v; end
                    2'd2:    begin ma = p_op; mb = sin_v; end
                    default: begin ma = q_op; mb = cos_v; end
                endcase
            end
            ST_PLACE: begin
                case (cmd.step[1:0])
                    2'd0:    begin ma = bx; mb = t_reg[0]; end
                    2'd1:    begin ma = by; mb = t_reg[2]; end
                    2'd2:    begin ma = bx; mb = t_reg[1]; end
                    default: begin ma = by; mb = t_reg[3]; end
                endcase
            end
            default: ;
        endcase
    end

    // reduction, folding and cordic step terms
    always_comb begin
        sub_v = FULL_TURN <<< (RED_KMAX - int'(cmd.step));
        rr0   = neg_reg ? -ANG_W'(mag_reg) : ANG_W'(mag_reg);
        rr1   = (rr0 >= HALF_A) ? rr0 - FULL_A : rr0;
        rr2   = (rr1 < -HALF_A) ? rr1 + FULL_A : rr1;
        fneg  = 1'b0;
        rr3   = rr2;
        if (rr2 > QUART_A) begin
            rr3  = rr2 - HALF_A;
            fneg = 1'b1;
        end else if (rr2 < -QUART_A) begin
            rr3  = rr2 + HALF_A;
            fneg = 1'b1;
        end
        dx = y_reg >>> cmd.step;
        dy = x_reg >>> cmd.step;
        at = atan_q30(5'(cmd.step));
    end

    always_ff @(posedge aclk) begin
        prod_reg <= ma * mb;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            eps_reg       <= 1'b0;
            ud_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < 6; i++) t_reg[i] <= '0;
            t_reg[0] <= ONE_FX;
            t_reg[3] <= ONE_FX;
            for (int i = 0; i < 4; i++) ub_reg[i] <= '0;
        end else begin
            if (cfg_wr_en) eps_reg <= cfg_wr_data;
            if (out_ready) out_valid_reg <= 1'b0;

            if (cmd.load) begin
                op_reg  <= op_t'(in_user[1:0]);
                bp_reg  <= in_user[2];
                vx_reg  <= in_data[31:0];
                vy_reg  <= in_data[63:32];
                lx_reg  <= in_data[127:96];
                ly_reg  <= in_data[159:128];
                hx_reg  <= in_data[191:160];
                hy_reg  <= in_data[223:192];
                neg_reg <= ang_in[DATA_W-1];
                mag_reg <= ang_in[DATA_W-1] ? -(DATA_W+1)'(ang_in) : (DATA_W+1)'(ang_in);
            end

            case (cmd.phase)
                ST_SCALE: begin
                    if (sidx != 3'd0) t_reg[widx] <= sat32(pr);
                end
                ST_TRANS: begin
                    t_reg[4] <= sat32(ACC_W'(t_reg[4]) + ACC_W'(vx_reg));
                    t_reg[5] <= sat32(ACC_W'(t_reg[5]) + ACC_W'(vy_reg));
                end
                ST_RED: begin
                    if (PROD_W'(mag_reg) >= sub_v)
                        mag_reg <= mag_reg - (DATA_W+1)'(sub_v);
                end
                ST_FOLD: begin
                    r_reg    <= rr3[DATA_W-1:0];
                    fneg_reg <= fneg;
                end
                ST_ZRND: begin
                    z_reg <= CRD_W'(pr);
                    x_reg <= CRD_W'(INV_GAIN);
                    y_reg <= '0;
                end
                ST_CORD: begin
                    if (!z_reg[CRD_W-1]) begin
                        x_reg <= x_reg - dx;
                        y_reg <= y_reg + dy;
                        z_reg <= z_reg - CRD_W'(at);
                    end else begin
                        x_reg <= x_reg + dx;
                        y_reg <= y_reg - dy;
                        z_reg <= z_reg + CRD_W'(at);
                    end
                end
                ST_ROT: begin
                    case (cmd.step[2:0])
                        3'd1: acc0_reg <= pe;
                        3'd2: acc0_reg <= acc0_reg - pe;
                        3'd3: acc1_reg <= pe;
                        3'd4: acc1_reg <= acc1_reg + pe;
                        3'd5: begin
                            t_reg[ie] <= sat32(rnd_shift(acc0_reg, ANG_FRAC));
                            t_reg[io] <= sat32(rnd_shift(acc1_reg, ANG_FRAC));
                        end
                        default: ;
                    endcase
                end
                ST_PLACE: begin
                    case (cmd.step[2:0])
                        3'd0: acc0_reg <= ACC_W'(t_reg[4]);
                        3'd1: acc0_reg <= acc0_reg + pr;
                        3'd2: begin
                            acc0_reg <= acc0_reg + pr;
                            acc1_reg <= ACC_W'(t_reg[5]);
                        end
                        3'd3: acc1_reg <= acc1_reg + pr;
                        3'd4: acc1_reg <= acc1_reg + pr;
                        3'd5: begin
                            ud_reg <= 1'b1;
                            if (!ud_reg || sat_x < ub_reg[0]) ub_reg[0] <= sat_x;
                            if (!ud_reg || sat_y < ub_reg[1]) ub_reg[1] <= sat_y;
                            if (!ud_reg || sat_x > ub_reg[2]) ub_reg[2] <= sat_x;
                            if (!ud_reg || sat_y > ub_reg[3]) ub_reg[3] <= sat_y;
                        end
                        default: ;
                    endcase
                end
                default: ;
            endcase

            if (cmd.out_load) begin
                out_valid_reg <= 1'b1;
                out_user_reg  <= ud_reg;
                out_data_reg  <= {ub_reg[3], ub_reg[2], ub_reg[1], ub_reg[0],
                                  t_reg[5], t_reg[4], t_reg[3], t_reg[2], t_reg[1], t_reg[0]};
                if (op_reg == OP_PLACE) begin
                    for (int i = 0; i < 6; i++) t_reg[i] <= '0;
                    t_reg[0] <= ONE_FX;
                    t_reg[3] <= ONE_FX;
                end
            end
        end
    end

    assign status.box_en   = eps_reg & bp_reg;
    assign status.out_busy = out_valid_reg & ~out_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign out_user  = out_user_reg;

endmodule

`default_nettype wire
